// File: sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int PRIO_W          = 32;
	localparam int TAG_W           = 9;
	localparam int OCC_W           = 9;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} spq_status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} spq_op_t;

	typedef struct packed {
		logic              kind;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  payload;
	} spq_req_t;

	typedef struct packed {
		spq_status_t       status;
		logic [TAG_W-1:0]  popped_payload;
		logic [OCC_W-1:0]  occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} spq_entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		spq_op_t           op;
		logic [PRIO_W-1:0] key;
		logic [TAG_W-1:0]  tag;
	} spq_cmd_t;

endpackage
`default_nettype wire

// File: sv/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 9
) (
	input  wire logic                clk,
	input  wire spq_pkg::spq_cmd_t   cmd,
	input  wire logic [CNT_W-1:0]    count,
	input  wire spq_pkg::spq_entry_t left,
	input  wire logic                left_lt,
	input  wire spq_pkg::spq_entry_t right,
	output spq_pkg::spq_entry_t      entry,
	output logic                     lt
);

	spq_pkg::spq_entry_t entry_q;
	logic                occupied;

	assign occupied = count > CNT_W'(IDX);
	// stored entry sorts strictly ahead of the incoming key
	assign lt       = occupied && (entry_q.prio < cmd.key);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			spq_pkg::OP_INSERT: begin
				if (!lt) begin
					// first cell at or past the insertion point takes the new entry
					if (IDX == 0 || left_lt) begin
						entry_q <= '{prio: cmd.key, tag: cmd.tag};
					end else begin
						entry_q <= left;
					end
				end
			end
			spq_pkg::OP_POP: begin
				entry_q <= right;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted min-priority queue built as a chain of cells.
// Request channel (req_valid/req_ready/req): kind selects insert or pop; an
// insert carries priority_req and payload, a pop ignores both.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request with status, popped_payload and occupancy after the request.
// Every cell compares its entry against the broadcast key; on insert the
// cells at or past the insertion point shift one place toward the tail, and on pop every cell shifts one
// place toward the head. The response is registered when the request is accepted and is valid in the next
// cycle; one request is accepted every cycle while the receiver takes the responses.
// An insert into a full queue is dropped with status full; a pop on an
// empty queue returns payload zero with status empty.
// Reset clears the occupancy count and the response valid flag; the cell
// contents need no clearing since only cells below the count are read.
// When the receiver stalls, the response holds and req_ready falls until
// the pending response is taken; a response taken in the same cycle lets a
// new request in.
module sorted_priority_queue_core #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire spq_pkg::spq_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output spq_pkg::spq_rsp_t      rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                rsp_valid_q;
	spq_pkg::spq_rsp_t   rsp_q;
	spq_pkg::spq_rsp_t   rsp_nxt;
	spq_pkg::spq_cmd_t   cmd;
	logic                req_fire;
	logic                full;
	logic                empty;

	spq_pkg::spq_entry_t ent [QUEUE_DEPTH];
	logic                lt  [QUEUE_DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		cmd       = '{op: spq_pkg::OP_HOLD, key: req.priority_req, tag: req.payload};
		count_nxt = count_q;
		rsp_nxt   = '{status: spq_pkg::STATUS_DONE, popped_payload: '0,
			occupancy: spq_pkg::OCC_W'(count_q)};
		if (req.kind == spq_pkg::KIND_INSERT) begin
			if (full) begin
				rsp_nxt.status = spq_pkg::STATUS_FULL;
			end else begin
				cmd.op    = spq_pkg::OP_INSERT;
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				rsp_nxt.status = spq_pkg::STATUS_EMPTY;
			end else begin
				cmd.op                 = spq_pkg::OP_POP;
				count_nxt              = count_q - CNT_W'(1);
				rsp_nxt.popped_payload = ent[0].tag;
			end
		end
		rsp_nxt.occupancy = spq_pkg::OCC_W'(count_nxt);
		if (!req_fire) begin
			cmd.op = spq_pkg::OP_HOLD;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::spq_entry_t left_ent;
		spq_pkg::spq_entry_t right_ent;
		logic                left_lt;

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_lt  = 1'b0;
		end else begin : g_body
			assign left_ent = ent[i-1];
			assign left_lt  = lt[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_ent = ent[i];
		end else begin : g_next
			assign right_ent = ent[i+1];
		end

		spq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.count   (count_q),
			.left    (left_ent),
			.left_lt (left_lt),
			.right   (right_ent),
			.entry   (ent[i]),
			.lt      (lt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy exceeds queue depth");

	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp_valid_q)
		else $error("accepted request produced no response");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.kind == spq_pkg::KIND_INSERT && full
		|=> count_q == $past(count_q) && rsp_q.status == spq_pkg::STATUS_FULL)
		else $error("insert into full queue changed state");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.kind == spq_pkg::KIND_POP && empty
		|=> count_q == '0 && rsp_q.status == spq_pkg::STATUS_EMPTY
			&& rsp_q.popped_payload == '0)
		else $error("pop on empty queue misreported");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q > CNT_W'(1) |-> ent[0].prio <= ent[1].prio)
		else $error("head entries out of order");
`endif

endmodule
`default_nettype wire
